[rtl/wsd_pkg.sv]
// ----------------------------------------------------------------------------
// wsd_pkg
// Shared types and constants for the websocket frame deframer.
// ----------------------------------------------------------------------------
package wsd_pkg;

  // default width of the payload length counter
  localparam int COUNT_BITS_DEF = 24;

  // max frame size register
  localparam int            MAX_SIZE_W   = 24;
  localparam logic [23:0]   MAX_SIZE_RST = 24'h10_0000;

  // width used for length against limit compares
  localparam int CMP_W = 32;

  // result kinds
  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_EMPTY   = 2'd1,
    KIND_ERROR   = 2'd2
  } wsd_kind_e;

  // one result item
  typedef struct packed {
    wsd_kind_e  kind;
    logic [7:0] data_byte;
    logic [3:0] frame_opcode;
    logic       fin_flag;
    logic       frame_end;
  } wsd_result_t;

endpackage

[rtl/wsd_in_if.sv]
// ----------------------------------------------------------------------------
// wsd_in_if
// Byte channel into the deframer: valid, ready and one received byte.
// ----------------------------------------------------------------------------
interface wsd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

[rtl/wsd_out_if.sv]
// ----------------------------------------------------------------------------
// wsd_out_if
// Result channel out of the deframer: valid, ready and one result item.
// ----------------------------------------------------------------------------
interface wsd_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] data_byte;
  logic [3:0] frame_opcode;
  logic       fin_flag;
  logic       frame_end;

  modport source (
    output valid, output kind, output data_byte, output frame_opcode,
    output fin_flag, output frame_end, input ready
  );
  modport sink (
    input valid, input kind, input data_byte, input frame_opcode,
    input fin_flag, input frame_end, output ready
  );
endinterface

[rtl/wsd_cfg_if.sv]
// ----------------------------------------------------------------------------
// wsd_cfg_if
// Configuration write channel carrying the max frame size register.
// ----------------------------------------------------------------------------
interface wsd_cfg_if;
  logic        valid;
  logic        ready;
  logic [23:0] max_frame_size;

  modport source (output valid, output max_frame_size, input ready);
  modport sink   (input valid, input max_frame_size, output ready);
endinterface

[rtl/wsd_parser.sv]
// ----------------------------------------------------------------------------
// wsd_parser
// Frame header FSM and payload unmasking, one byte per cycle on byte_fire_i.
// ----------------------------------------------------------------------------
module wsd_parser #(
  parameter int CountBits = wsd_pkg::COUNT_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          byte_fire_i,
  input  logic [7:0]                    byte_i,
  input  logic [wsd_pkg::MAX_SIZE_W-1:0] max_size_i,
  output logic                          res_valid_o,
  output wsd_pkg::wsd_result_t          res_o
);

  localparam logic [2:0] PH_FIRST   = 3'd0;
  localparam logic [2:0] PH_LEN     = 3'd1;
  localparam logic [2:0] PH_EXT16   = 3'd2;
  localparam logic [2:0] PH_EXT64   = 3'd3;
  localparam logic [2:0] PH_MASK    = 3'd4;
  localparam logic [2:0] PH_PAYLOAD = 3'd5;

  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;
  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;
  localparam logic [3:0] KEY_BYTES   = 4'd4;

  logic [2:0]           phase_q, phase_d;
  logic [3:0]           hdr_cnt_q, hdr_cnt_d;
  logic [CountBits-1:0] len_acc_q, len_acc_d;
  logic                 len_ovf_q, len_ovf_d;
  logic [CountBits-1:0] remaining_q, remaining_d;
  logic [31:0]          mask_key_q, mask_key_d;
  logic [1:0]           mask_idx_q, mask_idx_d;
  logic [3:0]           opcode_q, opcode_d;
  logic                 fin_q, fin_d;
  logic                 masked_q, masked_d;
  logic                 halted_q, halted_d;

  logic [CountBits-1:0] shift_acc;
  logic                 shift_ovf;
  logic [3:0]           hdr_inc;
  logic [CountBits-1:0] rem_dec;
  logic [1:0]           key_sel;
  logic [7:0]           key_byte;
  logic                 len_done;
  logic                 hdr_done;
  logic [CountBits-1:0] len_val;
  logic                 len_big;

  // extended length accumulation, with sticky overflow past the counter
  assign shift_acc = CountBits'({len_acc_q, byte_i});
  assign shift_ovf = len_ovf_q | (len_acc_q[CountBits-1 -: 8] != 8'd0);
  assign hdr_inc   = hdr_cnt_q + 4'd1;
  assign rem_dec   = remaining_q - CountBits'(1);

  // mask key byte, first key byte sits in the top bits
  assign key_sel  = 2'd3 - mask_idx_q;
  assign key_byte = mask_key_q[{key_sel, 3'b000} +: 8];

  // next state and result
  always_comb begin
    phase_d     = phase_q;
    hdr_cnt_d   = hdr_cnt_q;
    len_acc_d   = len_acc_q;
    len_ovf_d   = len_ovf_q;
    remaining_d = remaining_q;
    mask_key_d  = mask_key_q;
    mask_idx_d  = mask_idx_q;
    opcode_d    = opcode_q;
    fin_d       = fin_q;
    masked_d    = masked_q;
    halted_d    = halted_q;
    len_done    = 1'b0;
    hdr_done    = 1'b0;
    len_val     = '0;
    len_big     = 1'b0;
    res_valid_o = 1'b0;
    res_o.kind         = wsd_pkg::KIND_PAYLOAD;
    res_o.data_byte    = 8'd0;
    res_o.frame_opcode = opcode_q;
    res_o.fin_flag     = fin_q;
    res_o.frame_end    = 1'b0;

    if (byte_fire_i && !halted_q) begin
      case (phase_q)
        PH_FIRST: begin
          fin_d      = byte_i[7];
          opcode_d   = byte_i[3:0];
          mask_key_d = 32'd0;
          mask_idx_d = 2'd0;
          len_acc_d  = '0;
          len_ovf_d  = 1'b0;
          hdr_cnt_d  = 4'd0;
          phase_d    = PH_LEN;
        end
        PH_LEN: begin
          masked_d  = byte_i[7];
          hdr_cnt_d = 4'd0;
          len_acc_d = '0;
          len_ovf_d = 1'b0;
          if (byte_i[6:0] == LEN_EXT16) begin
            phase_d = PH_EXT16;
          end else if (byte_i[6:0] == LEN_EXT64) begin
            phase_d = PH_EXT64;
          end else begin
            len_done  = 1'b1;
            len_val   = CountBits'(byte_i[6:0]);
            len_acc_d = len_val;
          end
        end
        PH_EXT16, PH_EXT64: begin
          len_acc_d = shift_acc;
          len_ovf_d = shift_ovf;
          hdr_cnt_d = hdr_inc;
          if (hdr_inc >= ((phase_q == PH_EXT16) ? EXT16_BYTES : EXT64_BYTES)) begin
            len_done = 1'b1;
            len_val  = shift_acc;
            len_big  = shift_ovf;
          end
        end
        PH_MASK: begin
          mask_key_d = {mask_key_q[23:0], byte_i};
          hdr_cnt_d  = hdr_inc;
          if (hdr_inc >= KEY_BYTES) begin
            hdr_done = 1'b1;
          end
        end
        PH_PAYLOAD: begin
          mask_idx_d      = mask_idx_q + 2'd1;
          remaining_d     = rem_dec;
          res_valid_o     = 1'b1;
          res_o.data_byte = byte_i ^ key_byte;
          if (rem_dec == '0) begin
            phase_d         = PH_FIRST;
            res_o.frame_end = 1'b1;
          end
        end
        default: begin
          phase_d = PH_FIRST;
        end
      endcase

      // payload length known: size check, then error and halt, or mask key or payload
      if (len_done) begin
        if (len_big ||
            (wsd_pkg::CMP_W'(len_val) > wsd_pkg::CMP_W'(max_size_i))) begin
          halted_d        = 1'b1;
          phase_d         = PH_FIRST;
          res_valid_o     = 1'b1;
          res_o.kind      = wsd_pkg::KIND_ERROR;
          res_o.frame_end = 1'b1;
        end else begin
          remaining_d = len_val;
          hdr_cnt_d   = 4'd0;
          if (masked_d) begin
            phase_d = PH_MASK;
          end else begin
            hdr_done = 1'b1;
          end
        end
      end

      // header complete: empty frame closes at once
      if (hdr_done) begin
        mask_idx_d = 2'd0;
        if (remaining_d == '0) begin
          phase_d         = PH_FIRST;
          res_valid_o     = 1'b1;
          res_o.kind      = wsd_pkg::KIND_EMPTY;
          res_o.frame_end = 1'b1;
        end else begin
          phase_d = PH_PAYLOAD;
        end
      end
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_FIRST;
      hdr_cnt_q   <= 4'd0;
      len_acc_q   <= '0;
      len_ovf_q   <= 1'b0;
      remaining_q <= '0;
      mask_key_q  <= 32'd0;
      mask_idx_q  <= 2'd0;
      opcode_q    <= 4'd0;
      fin_q       <= 1'b0;
      masked_q    <= 1'b0;
      halted_q    <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      hdr_cnt_q   <= hdr_cnt_d;
      len_acc_q   <= len_acc_d;
      len_ovf_q   <= len_ovf_d;
      remaining_q <= remaining_d;
      mask_key_q  <= mask_key_d;
      mask_idx_q  <= mask_idx_d;
      opcode_q    <= opcode_d;
      fin_q       <= fin_d;
      masked_q    <= masked_d;
      halted_q    <= halted_d;
    end
  end

  // halt is sticky until reset
  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q |=> halted_q)
    else $error("halt flag cleared without reset");

  // an error result always halts the parser
  a_error_halts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.kind == wsd_pkg::KIND_ERROR) |=> halted_q)
    else $error("error result without halt");

  // payload phase always has bytes left to take
  a_payload_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_PAYLOAD) |-> (remaining_q != '0))
    else $error("payload phase with zero remaining");

  // a halted parser produces nothing
  a_halt_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q |-> !res_valid_o)
    else $error("result while halted");

endmodule

[rtl/wsd_out_reg.sv]
// ----------------------------------------------------------------------------
// wsd_out_reg
// Result register driving the output channel; frees its slot on transfer.
// ----------------------------------------------------------------------------
module wsd_out_reg (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  wsd_pkg::wsd_result_t res_i,
  output logic                 slot_free_o,
  wsd_out_if.source            out_o
);

  logic                 valid_q, valid_d;
  wsd_pkg::wsd_result_t data_q;

  // slot is free when empty or drained this cycle
  assign slot_free_o = !valid_q || out_o.ready;
  assign valid_d     = load_i || (valid_q && !out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload, loaded only into a free slot
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= res_i;
    end
  end

  assign out_o.valid        = valid_q;
  assign out_o.kind         = data_q.kind;
  assign out_o.data_byte    = data_q.data_byte;
  assign out_o.frame_opcode = data_q.frame_opcode;
  assign out_o.fin_flag     = data_q.fin_flag;
  assign out_o.frame_end    = data_q.frame_end;

  // never overwrite a result that has not been transferred
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> slot_free_o)
    else $error("result register overwritten");

  // a loaded result is shown next cycle
  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |=> valid_q)
    else $error("loaded result not valid");

  // a held result keeps its payload
  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !out_o.ready) |=> $stable(data_q))
    else $error("held result changed");

endmodule

[rtl/websocket_frame_deframer.sv]
// an accepted byte goes from the input register through the parser into the result register
// throughput: one byte per cycle while the result slot is free
// both channels run at full rate via input and result registers while output is ready
// reset clears the parser to expect a new frame and sets max_frame_size to 1 MiB
// ----------------------------------------------------------------------------
// websocket_frame_deframer
// Byte-serial websocket frame parser: header decode, size check, unmasking.
// ----------------------------------------------------------------------------
module websocket_frame_deframer #(
  parameter int COUNT_BITS = wsd_pkg::COUNT_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  wsd_in_if.sink     in_i,
  wsd_cfg_if.sink    cfg_i,
  wsd_out_if.source  out_o
);

  logic                          in_vld_q, in_vld_d;
  logic [7:0]                    in_byte_q;
  logic [wsd_pkg::MAX_SIZE_W-1:0] max_size_q;
  logic                          slot_free;
  logic                          advance;
  logic                          res_valid;
  wsd_pkg::wsd_result_t          res;

  // input register moves on when the result slot can take its outcome
  assign advance    = in_vld_q && slot_free;
  assign in_i.ready = !in_vld_q || advance;
  assign in_vld_d   = (in_i.valid && in_i.ready) || (in_vld_q && !advance);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_byte_q <= in_i.in_byte;
    end
  end

  // max frame size register
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_size_q <= wsd_pkg::MAX_SIZE_RST;
    end else if (cfg_i.valid && cfg_i.ready) begin
      max_size_q <= cfg_i.max_frame_size;
    end
  end

  // header and payload parser
  wsd_parser #(
    .CountBits (COUNT_BITS)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .byte_fire_i (advance),
    .byte_i      (in_byte_q),
    .max_size_i  (max_size_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // result register
  wsd_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (res_valid),
    .res_i       (res),
    .slot_free_o (slot_free),
    .out_o       (out_o)
  );

endmodule
